// ===== rtl/pid_feedforward_controller_assert.svh =====
// Assertion macros shared by the controller RTL.
// Each macro expects clk and rst_n in scope.
`ifndef PID_FEEDFORWARD_CONTROLLER_ASSERT_SVH
`define PID_FEEDFORWARD_CONTROLLER_ASSERT_SVH

`ifndef SYNTH

`define PFC_ASSERT_IMPLY(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("%m: same-cycle check failed");

`define PFC_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("%m: next-cycle check failed");

`else

`define PFC_ASSERT_IMPLY(label, ante, cons)

`define PFC_ASSERT_NEXT(label, ante, cons)

`endif

`endif

// ===== rtl/pfc_pkg.sv =====
package pfc_pkg;

    localparam int DataW = 32;
    localparam int LimW  = 31;
    localparam int IdxW  = 3;
    localparam int FracW = 16;
    localparam int ProdW = 2 * DataW;
    localparam int TermW = ProdW - FracW;
    localparam int AccW  = TermW + 2;
    localparam int PartW = TermW + 4;

    localparam logic [IdxW-1:0] REG_KP   = 3'd0;
    localparam logic [IdxW-1:0] REG_KI   = 3'd1;
    localparam logic [IdxW-1:0] REG_KD   = 3'd2;
    localparam logic [IdxW-1:0] REG_FF   = 3'd3;
    localparam logic [IdxW-1:0] REG_ILIM = 3'd4;
    localparam logic [IdxW-1:0] REG_DLIM = 3'd5;

    typedef logic signed [DataW-1:0] q16_t;
    typedef logic signed [ProdW-1:0] prod_word_t;
    typedef logic signed [TermW-1:0] term_t;

    localparam q16_t Q16_MAX = {1'b0, {(DataW-1){1'b1}}};
    localparam q16_t Q16_MIN = {1'b1, {(DataW-1){1'b0}}};

    typedef struct packed {
        q16_t             kp;
        q16_t             ki;
        q16_t             kd;
        q16_t             ff;
        logic [LimW-1:0]  i_limit;
        logic [LimW-1:0]  d_limit;
    } cfg_t;

    typedef struct packed {
        logic mode;
        logic sample_due;
        q16_t measured;
        q16_t target;
        q16_t error_in;
    } sample_t;

    typedef struct packed {
        logic due;
        logic mode;
        q16_t err;
        q16_t target;
    } err_t;

    typedef struct packed {
        logic due;
        logic mode;
        logic flip;
        logic d_ok;
        q16_t err;
        q16_t target;
        q16_t diff;
    } diff_t;

    typedef struct packed {
        logic       due;
        logic       flip;
        prod_word_t p;
        prod_word_t i;
        prod_word_t d;
        prod_word_t f;
    } prod_t;

    typedef struct packed {
        logic                    due;
        q16_t                    integ;
        logic signed [PartW-1:0] part;
    } acc_t;

    // Drop the fraction bits of a product (floor towards minus infinity)
    function automatic term_t frac_drop(prod_word_t x);
        return x[ProdW-1:FracW];
    endfunction

endpackage

// ===== rtl/pfc_if.sv =====
interface pfc_sample_if import pfc_pkg::*; ();
    logic valid;
    logic ready;
    logic mode;
    logic sample_due;
    q16_t measured;
    q16_t target;
    q16_t error_in;

    modport source (output valid, mode, sample_due, measured, target, error_in, input ready);
    modport sink (input valid, mode, sample_due, measured, target, error_in, output ready);
endinterface

interface pfc_result_if import pfc_pkg::*; ();
    logic valid;
    logic ready;
    q16_t drive;

    modport source (output valid, drive, input ready);
    modport sink (input valid, drive, output ready);
endinterface

// ===== rtl/pfc_error.sv =====
`include "pid_feedforward_controller_assert.svh"

module pfc_error import pfc_pkg::*; (
    input  logic    clk,
    input  logic    rst_n,
    input  cfg_t    cfg,
    input  logic    in_valid,
    output logic    in_ready,
    input  sample_t in_data,
    output logic    out_valid,
    input  logic    out_ready,
    output diff_t   out_data
);

    logic    s1_v_reg;
    sample_t s1_reg;
    logic    s2_v_reg;
    err_t    s2_reg;
    err_t    s2_next;
    logic    s3_v_reg;
    diff_t   s3_reg;
    diff_t   s3_next;
    q16_t    last_err_reg;

    logic s1_rdy;
    logic s2_rdy;
    logic s3_rdy;
    logic s1_load;
    logic s2_load;
    logic s3_load;

    logic signed [DataW:0] sub_wide;
    logic signed [DataW:0] diff_wide;
    logic        [DataW:0] diff_mag;

    assign s3_rdy  = !s3_v_reg || out_ready;
    assign s2_rdy  = !s2_v_reg || s3_rdy;
    assign s1_rdy  = !s1_v_reg || s2_rdy;
    assign s1_load = in_valid && s1_rdy;
    assign s2_load = s1_v_reg && s2_rdy;
    assign s3_load = s2_v_reg && s3_rdy;

    assign in_ready  = s1_rdy;
    assign out_valid = s3_v_reg;
    assign out_data  = s3_reg;

    // Error: saturated difference in mode 0, given error in mode 1
    always_comb
    begin
        sub_wide = (DataW+1)'(s1_reg.target) - (DataW+1)'(s1_reg.measured);
        s2_next.due    = s1_reg.sample_due;
        s2_next.mode   = s1_reg.mode;
        s2_next.target = s1_reg.target;
        if (s1_reg.mode)
        begin
            s2_next.err = s1_reg.error_in;
        end
        else if (sub_wide[DataW] != sub_wide[DataW-1])
        begin
            s2_next.err = sub_wide[DataW] ? Q16_MIN : Q16_MAX;
        end
        else
        begin
            s2_next.err = sub_wide[DataW-1:0];
        end
    end

    // Change in error, its limit test and the sign flip
    always_comb
    begin
        diff_wide = (DataW+1)'(s2_reg.err) - (DataW+1)'(last_err_reg);
        diff_mag  = diff_wide[DataW] ? -diff_wide : diff_wide;
        s3_next.due    = s2_reg.due;
        s3_next.mode   = s2_reg.mode;
        s3_next.err    = s2_reg.err;
        s3_next.target = s2_reg.target;
        s3_next.diff   = diff_wide[DataW-1:0];
        s3_next.d_ok   = diff_mag <= {2'b00, cfg.d_limit};
        s3_next.flip   = s2_reg.err[DataW-1] ^ last_err_reg[DataW-1];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_v_reg     <= 1'b0;
            s2_v_reg     <= 1'b0;
            s3_v_reg     <= 1'b0;
            last_err_reg <= '0;
        end
        else
        begin
            if (s1_rdy)
            begin
                s1_v_reg <= in_valid;
            end
            if (s2_rdy)
            begin
                s2_v_reg <= s1_v_reg;
            end
            if (s3_rdy)
            begin
                s3_v_reg <= s2_v_reg;
            end
            if (s3_load && s2_reg.due)
            begin
                last_err_reg <= s2_reg.err;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_load)
        begin
            s1_reg <= in_data;
        end
        if (s2_load)
        begin
            s2_reg <= s2_next;
        end
        if (s3_load)
        begin
            s3_reg <= s3_next;
        end
    end

    `PFC_ASSERT_NEXT(a_last_err_hold, !(s3_load && s2_reg.due), $stable(last_err_reg))

endmodule

// ===== rtl/pfc_mult.sv =====
module pfc_mult import pfc_pkg::*; (
    input  logic  clk,
    input  logic  rst_n,
    input  cfg_t  cfg,
    input  logic  in_valid,
    output logic  in_ready,
    input  diff_t in_data,
    output logic  out_valid,
    input  logic  out_ready,
    output prod_t out_data
);

    logic  v_reg;
    prod_t prod_reg;
    prod_t prod_next;
    logic  rdy;

    assign rdy       = !v_reg || out_ready;
    assign in_ready  = rdy;
    assign out_valid = v_reg;
    assign out_data  = prod_reg;

    always_comb
    begin
        prod_next.due  = in_data.due;
        prod_next.flip = in_data.flip;
        prod_next.p    = ProdW'(cfg.kp) * ProdW'(in_data.err);
        prod_next.i    = ProdW'(cfg.ki) * ProdW'(in_data.err);
        prod_next.d    = in_data.d_ok ? ProdW'(cfg.kd) * ProdW'(in_data.diff) : '0;
        // Mode 1 takes the gain as a plain offset: align it so the fraction drop restores it
        prod_next.f    = in_data.mode ? {{(ProdW-DataW-FracW){cfg.ff[DataW-1]}},
                                         cfg.ff, {FracW{1'b0}}}
                                      : ProdW'(cfg.ff) * ProdW'(in_data.target);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= 1'b0;
        end
        else if (rdy)
        begin
            v_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && rdy)
        begin
            prod_reg <= prod_next;
        end
    end

endmodule

// ===== rtl/pfc_sum.sv =====
`include "pid_feedforward_controller_assert.svh"

module pfc_sum import pfc_pkg::*; (
    input  logic  clk,
    input  logic  rst_n,
    input  cfg_t  cfg,
    input  logic  in_valid,
    output logic  in_ready,
    input  prod_t in_data,
    output logic  out_valid,
    input  logic  out_ready,
    output q16_t  drive
);

    logic  d_v_reg;
    acc_t  d_reg;
    acc_t  d_next;
    logic  e_v_reg;
    q16_t  drive_reg;
    q16_t  drive_next;
    q16_t  integral_reg;
    q16_t  held_reg;

    logic d_rdy;
    logic e_rdy;
    logic d_load;
    logic e_load;

    logic signed [AccW-1:0]  acc;
    logic signed [AccW-1:0]  lim;
    logic signed [AccW-1:0]  acc_clamped;
    logic signed [PartW-1:0] sum;
    q16_t                    sum_sat;

    assign e_rdy  = !e_v_reg || out_ready;
    assign d_rdy  = !d_v_reg || e_rdy;
    assign d_load = in_valid && d_rdy;
    assign e_load = d_v_reg && e_rdy;

    assign in_ready  = d_rdy;
    assign out_valid = e_v_reg;
    assign drive     = drive_reg;

    // Integral update, and the other three terms summed alongside
    always_comb
    begin
        acc = AccW'(integral_reg) + AccW'(frac_drop(in_data.i));
        lim = AccW'({1'b0, cfg.i_limit});
        if (in_data.flip)
        begin
            acc_clamped = '0;
        end
        else if (acc > lim)
        begin
            acc_clamped = lim;
        end
        else if (acc < -lim)
        begin
            acc_clamped = -lim;
        end
        else
        begin
            acc_clamped = acc;
        end
        d_next.due   = in_data.due;
        d_next.integ = acc_clamped[DataW-1:0];
        d_next.part  = PartW'(frac_drop(in_data.p)) + PartW'(frac_drop(in_data.d))
                     + PartW'(frac_drop(in_data.f));
    end

    // Final sum, saturate, or repeat the held drive
    always_comb
    begin
        sum = d_reg.part + PartW'(d_reg.integ);
        if (sum > PartW'(Q16_MAX))
        begin
            sum_sat = Q16_MAX;
        end
        else if (sum < PartW'(Q16_MIN))
        begin
            sum_sat = Q16_MIN;
        end
        else
        begin
            sum_sat = sum[DataW-1:0];
        end
        drive_next = d_reg.due ? sum_sat : held_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            d_v_reg      <= 1'b0;
            e_v_reg      <= 1'b0;
            integral_reg <= '0;
            held_reg     <= '0;
        end
        else
        begin
            if (d_rdy)
            begin
                d_v_reg <= in_valid;
            end
            if (e_rdy)
            begin
                e_v_reg <= d_v_reg;
            end
            if (d_load && in_data.due)
            begin
                integral_reg <= d_next.integ;
            end
            if (e_load && d_reg.due)
            begin
                held_reg <= sum_sat;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (d_load)
        begin
            d_reg <= d_next;
        end
        if (e_load)
        begin
            drive_reg <= drive_next;
        end
    end

    `PFC_ASSERT_NEXT(a_held_tracks_drive, e_load && d_reg.due, held_reg == drive_reg)
    `PFC_ASSERT_NEXT(a_integral_hold, !(d_load && in_data.due), $stable(integral_reg))

endmodule

// ===== rtl/pid_feedforward_controller.sv =====
// PID controller with feedforward, signed Q16.16.
// Channels: request carries mode, sample_due, measured, target and error_in;
// response carries drive. Both use valid/ready; a transfer happens on a clock
// edge with valid and ready high. Gains and limits are written through the
// cfg_we / cfg_index / cfg_data port while no request is in flight.
// A request is first held in an input register ahead of the stages below.
// Throughput: one request per cycle while drive is taken; each stage holds
// one request, so a request is taken whenever any stage downstream has room.
// Error and change in error, the four 32x32 products, the integral
// accumulator and the final saturating add are each one register stage.
// A request with sample_due low returns the last computed drive and leaves
// all controller state as it was.
// Reset clears the pipeline, the error history, the integral and the held
// drive, sets the gains to zero and both limits to full scale.
// When the receiver holds ready low, drive stays on the output and the
// stages fill; request ready falls only once every stage is occupied.
`include "pid_feedforward_controller_assert.svh"

module pid_feedforward_controller import pfc_pkg::*; (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             cfg_we,
    input  logic [IdxW-1:0]  cfg_index,
    input  logic [DataW-1:0] cfg_data,
    pfc_sample_if.sink       request,
    pfc_result_if.source     response
);

    q16_t            kp_reg;
    q16_t            ki_reg;
    q16_t            kd_reg;
    q16_t            ff_reg;
    logic [LimW-1:0] ilim_reg;
    logic [LimW-1:0] dlim_reg;
    cfg_t            cfg;

    sample_t in_data;
    logic    err_valid;
    logic    err_ready;
    diff_t   err_data;
    logic    prod_valid;
    logic    prod_ready;
    prod_t   prod_data;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            kp_reg   <= '0;
            ki_reg   <= '0;
            kd_reg   <= '0;
            ff_reg   <= '0;
            ilim_reg <= '1;
            dlim_reg <= '1;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_KP:   kp_reg   <= cfg_data;
                REG_KI:   ki_reg   <= cfg_data;
                REG_KD:   kd_reg   <= cfg_data;
                REG_FF:   ff_reg   <= cfg_data;
                REG_ILIM: ilim_reg <= cfg_data[LimW-1:0];
                REG_DLIM: dlim_reg <= cfg_data[LimW-1:0];
                default:  ;
            endcase
        end
    end

    assign cfg.kp      = kp_reg;
    assign cfg.ki      = ki_reg;
    assign cfg.kd      = kd_reg;
    assign cfg.ff      = ff_reg;
    assign cfg.i_limit = ilim_reg;
    assign cfg.d_limit = dlim_reg;

    assign in_data.mode       = request.mode;
    assign in_data.sample_due = request.sample_due;
    assign in_data.measured   = request.measured;
    assign in_data.target     = request.target;
    assign in_data.error_in   = request.error_in;

    pfc_error u_error (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .in_valid  (request.valid),
        .in_ready  (request.ready),
        .in_data   (in_data),
        .out_valid (err_valid),
        .out_ready (err_ready),
        .out_data  (err_data)
    );

    pfc_mult u_mult (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .in_valid  (err_valid),
        .in_ready  (err_ready),
        .in_data   (err_data),
        .out_valid (prod_valid),
        .out_ready (prod_ready),
        .out_data  (prod_data)
    );

    pfc_sum u_sum (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .in_valid  (prod_valid),
        .in_ready  (prod_ready),
        .in_data   (prod_data),
        .out_valid (response.valid),
        .out_ready (response.ready),
        .drive     (response.drive)
    );

    `PFC_ASSERT_IMPLY(a_stall_from_output, !request.ready, response.valid && !response.ready)

endmodule
